@@ rtl/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Types and fixed constants that the edge magnitude block and its units share.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned CH_W       = 8;   // one color component
  localparam int unsigned PIX_W      = 24;  // packed red, green, blue
  localparam int unsigned SUM_W      = 10;  // one side of a Sobel kernel, at most 1020
  localparam int unsigned SQ_W       = 21;  // gx*gx + gy*gy
  localparam int unsigned ROOT_W     = 11;  // integer root of a 21-bit value
  localparam int unsigned REM_W      = 12;  // square root remainder
  localparam int unsigned ROOT_STEPS = 11;  // one root bit per step
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned CFGW_W     = 11;  // width register
  localparam int unsigned CFGH_W     = 16;  // height register
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned NUM_CH     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [CH_W-1:0] EDGE_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;
  // window[row][column], row 0 is the top row, column 0 the oldest column
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic start;  // capture a window and begin
    logic take;   // result has been moved out
  } mag_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mag_sts_t;

endpackage

@@ rtl/sem_if.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude channel interfaces
// Pixel input, edge output and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, op, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface sem_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_edge;
  logic [7:0] green_edge;
  logic [7:0] blue_edge;
  logic       frame_end;

  modport source (output valid, red_edge, green_edge, blue_edge, frame_end, input ready);
  modport sink   (input valid, red_edge, green_edge, blue_edge, frame_end, output ready);
endinterface

interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sobel_edge_magnitude_rgb_unit.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// 3x3 Sobel X/Y on each color channel of a raster pixel stream, rounded
// gradient magnitude saturated at 255, zero padding outside the frame.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                       Transfer when
//  pix_i    in   op, red_in, green_in, blue_in                 valid & ready
//  edge_o   out  red_edge, green_edge, blue_edge, frame_end    valid & ready
//  cfg_i    in   index (0 width, 1 height), data               valid & ready
//
// An item passes from transfer to a result in the output register through
// one line memory read with the window update, gradient, square, a
// bit-serial square root, and the move into the output register.
// Items without a result go back to idle after the line memory read.
// A new pixel is taken while the previous result still waits on edge_o;
// the square root unit holds its result while the output register is full.
// Reset clears the window, counters and control; the line memory is not
// cleared, since the row masks keep stale rows out of every result.
// The result for position m leaves with the input at position m+width+1, so
// width+1 flush items drain a frame.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sem_pix_if.sink      pix_i,
  sem_edge_if.source   edge_o,
  sem_cfg_if.sink      cfg_i
);

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1) + 1;
  localparam int unsigned CNT_W = WW + sem_pkg::ROW_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_MAG  = 2'd2;

  logic [1:0] st_q, st_d;

  // Configuration registers.
  logic [sem_pkg::CFGW_W-1:0] width_q;
  logic [sem_pkg::CFGH_W-1:0] height_q;
  logic [WW-1:0]              w_eff;
  logic [sem_pkg::ROW_W-1:0]  h_eff;
  logic [CNT_W-1:0]           total_q;

  // Position and window state.
  logic [COL_W-1:0]          col_q, col_d;
  logic [sem_pkg::ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  sem_pkg::win_t             win_q, win_d, mwin;
  sem_pkg::pix_t             pix_q;
  logic                      fe_q, fe_d;

  logic [2*sem_pkg::PIX_W-1:0] rd_data;
  sem_pkg::pix_t               up, lo;

  sem_pkg::mag_ctl_t mag_ctl;
  sem_pkg::mag_sts_t mag_sts;
  logic [sem_pkg::NUM_CH-1:0][sem_pkg::CH_W-1:0] mag_edge;

  logic in_xfer, out_free, emit;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = (st_q == ST_IDLE);
  assign in_xfer     = pix_i.valid && pix_i.ready;
  assign out_free    = !edge_o.valid || edge_o.ready;

  // Width or height zero counts as one, width above the line memory depth is clamped.
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q == '0) ? sem_pkg::ROW_W'(1) : height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::CFGW_W'(1024);
      height_q <= sem_pkg::CFGH_W'(1024);
      total_q  <= CNT_W'(1024 * 1024);
    end else begin
      if (cfg_i.valid && cfg_i.index == sem_pkg::REG_WIDTH) begin
        width_q <= cfg_i.data[sem_pkg::CFGW_W-1:0];
      end
      if (cfg_i.valid && cfg_i.index == sem_pkg::REG_HEIGHT) begin
        height_q <= cfg_i.data[sem_pkg::CFGH_W-1:0];
      end
      // Frame size registered so the multiply stays off the update path.
      total_q <= CNT_W'(w_eff) * CNT_W'(h_eff);
    end
  end

  // Line memory: read at the column on transfer, written back in the following
  // cycle with the rows moved up by one. Items are taken one at a time, so
  // a read never overlaps the pending write of the same column.
  sem_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (st_q == ST_RD),
    .wr_addr_i (col_q),
    .wr_data_i ({lo, pix_q})
  );

  assign up = rd_data[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
  assign lo = rd_data[sem_pkg::PIX_W-1:0];

  // Window update, position step, masks and frame accounting of one item.
  always_comb begin
    logic                      primed, last_col;
    logic [sem_pkg::ROW_W-1:0] crow;
    logic [WW-1:0]             ccol;
    logic [CNT_W-1:0]          cnt_inc;
    st_d  = st_q;
    col_d = col_q;
    row_d = row_q;
    cnt_d = cnt_q;
    fe_d  = fe_q;
    win_d = win_q;
    mwin  = win_q;
    emit  = 1'b0;

    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = up;
    win_d[1][2] = lo;
    win_d[2][2] = pix_q;

    primed   = (row_q >= sem_pkg::ROW_W'(2)) ||
               (row_q == sem_pkg::ROW_W'(1) && col_q != '0);
    last_col = (WW'(col_q) + WW'(1)) >= w_eff;

    // Center of the window that this item completes.
    if (col_q == '0) begin
      crow = row_q - sem_pkg::ROW_W'(2);
      ccol = w_eff - WW'(1);
    end else begin
      crow = row_q - sem_pkg::ROW_W'(1);
      ccol = WW'(col_q) - WW'(1);
    end

    mwin = win_d;
    for (int r = 0; r < 3; r++) begin
      if (crow == '0) begin
        mwin[0][r] = '0;
      end
      if (crow == h_eff - sem_pkg::ROW_W'(1)) begin
        mwin[2][r] = '0;
      end
      if (ccol == '0) begin
        mwin[r][0] = '0;
      end
      if (ccol + WW'(1) >= w_eff) begin
        mwin[r][2] = '0;
      end
    end

    cnt_inc = cnt_q + CNT_W'(1);

    case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          st_d = ST_RD;
        end
      end
      ST_RD: begin
        if (last_col) begin
          col_d = '0;
          row_d = row_q + sem_pkg::ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
        emit = (cnt_q != '0) || primed;
        if (emit) begin
          st_d = ST_MAG;
          if (cnt_inc >= total_q) begin
            fe_d  = 1'b1;
            cnt_d = '0;
            col_d = '0;
            row_d = '0;
          end else begin
            fe_d  = 1'b0;
            cnt_d = cnt_inc;
          end
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_MAG: begin
        if (mag_sts.done && out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign mag_ctl.start = (st_q == ST_RD) && emit;
  assign mag_ctl.take  = (st_q == ST_MAG) && mag_sts.done && out_free;

  sem_mag u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mag_ctl),
    .win_i  (mwin),
    .sts_o  (mag_sts),
    .edge_o (mag_edge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
      fe_q  <= 1'b0;
      win_q <= '0;
    end else begin
      st_q <= st_d;
      fe_q <= fe_d;
      if (st_q == ST_RD) begin
        col_q <= col_d;
        row_q <= row_d;
        cnt_q <= cnt_d;
        win_q <= win_d;
      end
    end
  end

  // A flush item is a zero pixel.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pix_q <= pix_i.op ? '0 : {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_o.valid <= 1'b0;
    end else if (mag_ctl.take) begin
      edge_o.valid <= 1'b1;
    end else if (edge_o.ready) begin
      edge_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_ctl.take) begin
      edge_o.red_edge   <= mag_edge[2];
      edge_o.green_edge <= mag_edge[1];
      edge_o.blue_edge  <= mag_edge[0];
      edge_o.frame_end  <= fe_q;
    end
  end

  a_rd_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RD) |=> (st_q != ST_RD)) else $error("read stage repeated");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RD) |=> (cnt_q < total_q)) else $error("result count past frame size");
  a_done_in_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_sts.done |-> (st_q == ST_MAG)) else $error("magnitude result without item");
  a_take_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_ctl.take |-> out_free) else $error("output register overwritten");
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_ctl.start |-> !mag_sts.busy) else $error("window sent to a busy magnitude unit");

endmodule

@@ rtl/sem_line_mem.sv @@
// ----------------------------------------------------------------------------
// Sobel line memory
// Both line stores side by side in one synchronous memory, upper row in the
// high half, with a registered read port and one write port.
// ----------------------------------------------------------------------------
module sem_line_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [ADDR_W-1:0]        rd_addr_i,
  output logic [2*sem_pkg::PIX_W-1:0] rd_data_o,
  input  logic                     wr_en_i,
  input  logic [ADDR_W-1:0]        wr_addr_i,
  input  logic [2*sem_pkg::PIX_W-1:0] wr_data_i
);

  logic [2*sem_pkg::PIX_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ rtl/sem_mag.sv @@
// ----------------------------------------------------------------------------
// Sobel magnitude unit
// Gradients, squares and a bit-serial rounded square root for three channels.
// ----------------------------------------------------------------------------
module sem_mag (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sem_pkg::mag_ctl_t    ctl_i,
  input  sem_pkg::win_t        win_i,
  output sem_pkg::mag_sts_t    sts_o,
  output logic [sem_pkg::NUM_CH-1:0][sem_pkg::CH_W-1:0] edge_o
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_GRAD = 3'd1;
  localparam logic [2:0] M_SQ   = 3'd2;
  localparam logic [2:0] M_ROOT = 3'd3;
  localparam logic [2:0] M_DONE = 3'd4;

  logic [2:0]                  st_q, st_d;
  logic [sem_pkg::STEP_W-1:0]  step_q, step_d;
  sem_pkg::win_t               win_q;

  logic [sem_pkg::NUM_CH-1:0][sem_pkg::SUM_W-1:0]    ax_q, ay_q, ax_d, ay_d;
  logic [sem_pkg::NUM_CH-1:0][sem_pkg::SQ_W:0]       v_q, v_d;  // one pad bit on top
  logic [sem_pkg::NUM_CH-1:0][sem_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [sem_pkg::NUM_CH-1:0][sem_pkg::ROOT_W-1:0]   root_q, root_d;
  logic [sem_pkg::NUM_CH-1:0][sem_pkg::CH_W-1:0]     edge_q, edge_d;

  function automatic logic [sem_pkg::SUM_W-1:0] absdiff(
    input logic [sem_pkg::SUM_W-1:0] a, input logic [sem_pkg::SUM_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [sem_pkg::SUM_W-1:0] side(
    input logic [sem_pkg::CH_W-1:0] p0, input logic [sem_pkg::CH_W-1:0] p1,
    input logic [sem_pkg::CH_W-1:0] p2);
    return sem_pkg::SUM_W'(p0) + {1'b0, p1, 1'b0} + sem_pkg::SUM_W'(p2);
  endfunction

  always_comb begin
    logic [sem_pkg::CH_W-1:0] p [3][3];
    logic [sem_pkg::REM_W+1:0] rem_sh, trial;
    logic [sem_pkg::ROOT_W:0]  rnd;
    p      = '{default: '0};
    rem_sh = '0;
    trial  = '0;
    rnd    = '0;
    st_d   = st_q;
    step_d = step_q;
    ax_d   = ax_q;
    ay_d   = ay_q;
    v_d    = v_q;
    rem_d  = rem_q;
    root_d = root_q;
    edge_d = edge_q;
    case (st_q)
      M_IDLE: begin
        if (ctl_i.start) begin
          st_d = M_GRAD;
        end
      end
      M_GRAD: begin
        for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
              p[r][c] = win_q[r][c][ch*sem_pkg::CH_W +: sem_pkg::CH_W];
            end
          end
          ax_d[ch] = absdiff(side(p[0][2], p[1][2], p[2][2]), side(p[0][0], p[1][0], p[2][0]));
          ay_d[ch] = absdiff(side(p[2][0], p[2][1], p[2][2]), side(p[0][0], p[0][1], p[0][2]));
        end
        st_d = M_SQ;
      end
      M_SQ: begin
        for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
          v_d[ch]    = (sem_pkg::SQ_W+1)'(ax_q[ch] * ax_q[ch]) +
                       (sem_pkg::SQ_W+1)'(ay_q[ch] * ay_q[ch]);
          rem_d[ch]  = '0;
          root_d[ch] = '0;
        end
        step_d = '0;
        st_d   = M_ROOT;
      end
      M_ROOT: begin
        for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
          rem_sh = {rem_q[ch], v_q[ch][sem_pkg::SQ_W:sem_pkg::SQ_W-1]};
          trial  = (sem_pkg::REM_W+2)'({root_q[ch], 2'b01});
          if (rem_sh >= trial) begin
            rem_d[ch]  = sem_pkg::REM_W'(rem_sh - trial);
            root_d[ch] = {root_q[ch][sem_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            rem_d[ch]  = sem_pkg::REM_W'(rem_sh);
            root_d[ch] = {root_q[ch][sem_pkg::ROOT_W-2:0], 1'b0};
          end
          v_d[ch] = {v_q[ch][sem_pkg::SQ_W-2:0], 2'b00};
        end
        step_d = step_q + 1'b1;
        if (step_q == sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1)) begin
          st_d = M_DONE;
        end
        // Round to nearest: up when the remainder exceeds the floor root.
        if (step_q == sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1)) begin
          for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
            rnd = {1'b0, root_d[ch]} +
                  ((sem_pkg::ROOT_W'(rem_d[ch]) > root_d[ch] || rem_d[ch][sem_pkg::REM_W-1])
                   ? (sem_pkg::ROOT_W+1)'(1) : '0);
            edge_d[ch] = (rnd > (sem_pkg::ROOT_W+1)'(sem_pkg::EDGE_MAX))
                         ? sem_pkg::EDGE_MAX : rnd[sem_pkg::CH_W-1:0];
          end
        end
      end
      M_DONE: begin
        if (ctl_i.take) begin
          st_d = M_IDLE;
        end
      end
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == M_IDLE && ctl_i.start) begin
      win_q <= win_i;
    end
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    edge_q <= edge_d;
  end

  assign sts_o.busy = (st_q != M_IDLE);
  assign sts_o.done = (st_q == M_DONE);
  assign edge_o     = edge_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> (st_q == M_IDLE)) else $error("start while magnitude unit busy");
  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == M_SQ) |=> (st_q == M_ROOT && step_q == '0)) else $error("root did not start");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == M_DONE && !ctl_i.take) |=> (st_q == M_DONE && $stable(edge_q)))
    else $error("result lost before take");

endmodule
